### src/wcr_pkg.sv
// ----------------------------------------------------------------------------
// wcr_pkg
// Shared constants, payload types and the sRGB linearization table for the
// contrast ratio core.
// ----------------------------------------------------------------------------
package wcr_pkg;

    localparam int LUM_FRAC_BITS   = 16;
    localparam int RATIO_FRAC_BITS = 12;

    localparam int CH_W      = 8;
    localparam int FIELD_W   = 17;
    localparam int LUT_DEPTH = 256;

    // Luminance spans 0 .. 2^LUM_FRAC_BITS inclusive
    localparam int LUM_W   = LUM_FRAC_BITS + 1;
    // Ratio stays below 21.0, so five integer bits
    localparam int RATIO_W = RATIO_FRAC_BITS + 5;

    // Luminance weights in Q0.16
    localparam int WT_W    = 16;
    localparam int WT_FRAC = 16;
    localparam logic [WT_W-1:0] WT_RED   = 16'd13933;
    localparam logic [WT_W-1:0] WT_GREEN = 16'd46871;
    localparam logic [WT_W-1:0] WT_BLUE  = 16'd4732;
    localparam int ROUND_HALF = 1 << (WT_FRAC - 1);

    localparam int PROD_W = WT_W + LUM_W;
    localparam int SUM_W  = PROD_W + 2;

    // 0.05 in luminance units, rounded
    localparam int LUM_OFF = ((1 << LUM_FRAC_BITS) + 10) / 20;

    // Divider widths: hi+off and lo+off both stay below 2^LUM_W
    localparam int DVD_W = LUM_W + RATIO_FRAC_BITS;
    localparam int DVS_W = LUM_W;
    localparam int CMP_W = LUM_W + RATIO_W;

    // Pipeline layout
    localparam int LANE_STAGES  = 3;
    localparam int MERGE_STAGES = 1;
    localparam int PIPE_DEPTH   = LANE_STAGES + MERGE_STAGES + RATIO_W;

    // Width for the exact table build at elaboration
    localparam int BIG_W = 5 * (LUM_FRAC_BITS + 1) + 224;

    typedef logic [LUM_W-1:0] t_lin;
    typedef t_lin t_lut [LUT_DEPTH];

    typedef struct packed {
        logic [CH_W-1:0] a_red;
        logic [CH_W-1:0] a_green;
        logic [CH_W-1:0] a_blue;
        logic [CH_W-1:0] b_red;
        logic [CH_W-1:0] b_green;
        logic [CH_W-1:0] b_blue;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] contrast_ratio;
        logic [FIELD_W-1:0] luminance_a;
        logic [FIELD_W-1:0] luminance_b;
    } t_out;

    typedef struct packed {
        logic [LANE_STAGES-1:0] adv;
    } t_lane_ctl;

    typedef struct packed {
        logic [DVD_W-1:0] dvd;
        logic [DVS_W-1:0] dvs;
        logic [LUM_W-1:0] lum_a;
        logic [LUM_W-1:0] lum_b;
    } t_div_in;

    // Rounded sRGB transfer curve, exact: largest R with
    // (2R-1)^5 * D^12 <= N^12 * 2^(5(F+1)), N = 1000c + 14025, D = 269025.
    function automatic t_lin curve_entry(input int unsigned c);
        logic [BIG_W-1:0]   rhs;
        logic [BIG_W-1:0]   dpow;
        logic [BIG_W-1:0]   lhs;
        logic [LUM_W:0]     lo;
        logic [LUM_W:0]     hi;
        logic [LUM_W:0]     mid;
        logic [LUM_W+1:0]   odd;
        int                 i;
        int                 k;
        rhs  = BIG_W'(1);
        dpow = BIG_W'(1);
        for (i = 0; i < 12; i++) begin
            rhs  = rhs * BIG_W'(1000 * c + 14025);
            dpow = dpow * BIG_W'(269025);
        end
        rhs = rhs << (5 * (LUM_FRAC_BITS + 1));
        lo  = '0;
        hi  = (LUM_W+1)'(1) << LUM_FRAC_BITS;
        for (k = 0; k < LUM_W + 1; k++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + (LUM_W+1)'(1)) >> 1);
                odd = ((LUM_W+2)'(mid) << 1) - (LUM_W+2)'(1);
                lhs = dpow;
                for (i = 0; i < 5; i++) begin
                    lhs = lhs * BIG_W'(odd);
                end
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - (LUM_W+1)'(1);
                end
            end
        end
        return t_lin'(lo);
    endfunction

    function automatic t_lin lin_entry(input int unsigned c);
        logic [63:0] n;
        if (64'(c) * 64'd100000 <= 64'd1001640) begin
            n = (64'(c) * 64'd100) << (LUM_FRAC_BITS + 1);
            return t_lin'((n + 64'd329460) / 64'd658920);
        end else begin
            return curve_entry(c);
        end
    endfunction

    function automatic t_lut build_lin_tab();
        t_lut tab;
        for (int c = 0; c < LUT_DEPTH; c++) begin
            tab[c] = lin_entry(c);
        end
        return tab;
    endfunction

    localparam t_lut LIN_TAB = build_lin_tab();

endpackage

### src/wcag_contrast_ratio_core.sv
// ----------------------------------------------------------------------------
// wcag_contrast_ratio_core
// Relative luminance of two sRGB colors and their contrast ratio.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+-------------------------------------
//  input    | i_valid / o_ready        | i_data  : six 8-bit color channels
//  output   | o_valid / i_ready        | o_data  : ratio (Q.12), two lums
//
//  Pipe   : one transaction per cycle while the output is taken or a stage
//           is empty; PIPE_DEPTH stages (3 lane + 1 merge + RATIO_W divider
//           stages = 21 by default), the divider resolving one quotient bit per stage.
//  Reset  : synchronous, active low; clears only the stage valid bits.
//  Stalls : a stage advances when the output is taken or any stage at or
//           beyond it is empty, so bubbles close up and new transactions
//           enter while a finished result waits at the output.
//
// Structure: two luminance lanes (color a, color b) run side by side,
// a merge stage orders the luminances and adds the 0.05 offset, and a
// pipelined restoring divider forms (hi+off)*2^12/(lo+off).
// ----------------------------------------------------------------------------
module wcag_contrast_ratio_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  wcr_pkg::t_in    i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output wcr_pkg::t_out   o_data
);

    localparam int DEPTH   = wcr_pkg::PIPE_DEPTH;
    localparam int DIV_LO  = wcr_pkg::LANE_STAGES + wcr_pkg::MERGE_STAGES;

    logic [DEPTH-1:0]             r_vld;
    logic [DEPTH-1:0]             n_vld;
    logic [DEPTH-1:0]             adv;
    wcr_pkg::t_lane_ctl           lane_ctl;
    logic [wcr_pkg::LUM_W-1:0]    lum_a;
    logic [wcr_pkg::LUM_W-1:0]    lum_b;
    wcr_pkg::t_div_in             div_in;
    logic [wcr_pkg::RATIO_W-1:0]  quo;
    logic [wcr_pkg::LUM_W-1:0]    out_la;
    logic [wcr_pkg::LUM_W-1:0]    out_lb;

    // Stage k may load when the output drains or a hole exists at or past k
    for (genvar k = 0; k < DEPTH; k++) begin : g_adv
        assign adv[k] = i_ready | ~(&r_vld[DEPTH-1:k]);
    end

    always_comb begin
        n_vld[0] = adv[0] ? i_valid : r_vld[0];
        for (int k = 1; k < DEPTH; k++) begin
            n_vld[k] = adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    // Clear valid bits under reset, advance otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready      = adv[0];
    assign lane_ctl.adv = adv[wcr_pkg::LANE_STAGES-1:0];

    // Lane for the first color
    wcr_lum_lane u_lane_a (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_red   (i_data.a_red),
        .i_green (i_data.a_green),
        .i_blue  (i_data.a_blue),
        .o_lum   (lum_a)
    );

    // Lane for the second color
    wcr_lum_lane u_lane_b (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_red   (i_data.b_red),
        .i_green (i_data.b_green),
        .i_blue  (i_data.b_blue),
        .o_lum   (lum_b)
    );

    // Order luminances, build dividend and divisor
    wcr_merge u_merge (
        .i_clk   (i_clk),
        .i_adv   (adv[wcr_pkg::LANE_STAGES]),
        .i_lum_a (lum_a),
        .i_lum_b (lum_b),
        .o_div   (div_in)
    );

    // Ratio divider; its last stage doubles as the output register
    wcr_div_pipe u_div (
        .i_clk   (i_clk),
        .i_adv   (adv[DEPTH-1:DIV_LO]),
        .i_div   (div_in),
        .o_quo   (quo),
        .o_lum_a (out_la),
        .o_lum_b (out_lb)
    );

    assign o_valid               = r_vld[DEPTH-1];
    assign o_data.contrast_ratio = wcr_pkg::FIELD_W'(quo);
    assign o_data.luminance_a    = wcr_pkg::FIELD_W'(out_la);
    assign o_data.luminance_b    = wcr_pkg::FIELD_W'(out_lb);

    // Reset empties the pipe by the next edge
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // An accepted transaction always lands in the first stage
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transaction lost at pipe entry");

    // Ratio of ordered luminances is never below 1.0
    a_ratio_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.contrast_ratio
                    >= wcr_pkg::FIELD_W'(1 << wcr_pkg::RATIO_FRAC_BITS))
        else $error("contrast ratio below 1.0");

    // Equal luminances give exactly 1.0
    a_equal_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.luminance_a == o_data.luminance_b))
        |-> o_data.contrast_ratio == wcr_pkg::FIELD_W'(1 << wcr_pkg::RATIO_FRAC_BITS))
        else $error("equal luminances but ratio is not 1.0");

endmodule

### src/wcr_lum_lane.sv
// ----------------------------------------------------------------------------
// wcr_lum_lane
// One luminance lane: table lookup, weighted products, rounded sum.
// ----------------------------------------------------------------------------
module wcr_lum_lane (
    input  logic                          i_clk,
    input  wcr_pkg::t_lane_ctl            i_ctl,
    input  logic [wcr_pkg::CH_W-1:0]      i_red,
    input  logic [wcr_pkg::CH_W-1:0]      i_green,
    input  logic [wcr_pkg::CH_W-1:0]      i_blue,
    output logic [wcr_pkg::LUM_W-1:0]     o_lum
);

    logic [wcr_pkg::LUM_W-1:0]  r_lin_red;
    logic [wcr_pkg::LUM_W-1:0]  r_lin_green;
    logic [wcr_pkg::LUM_W-1:0]  r_lin_blue;
    logic [wcr_pkg::PROD_W-1:0] r_prod_red;
    logic [wcr_pkg::PROD_W-1:0] r_prod_green;
    logic [wcr_pkg::PROD_W-1:0] r_prod_blue;
    logic [wcr_pkg::SUM_W-1:0]  n_sum;
    logic [wcr_pkg::LUM_W-1:0]  r_lum;

    // Linearize
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r_lin_red   <= wcr_pkg::LIN_TAB[i_red];
            r_lin_green <= wcr_pkg::LIN_TAB[i_green];
            r_lin_blue  <= wcr_pkg::LIN_TAB[i_blue];
        end
    end

    // Weight
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[1]) begin
            r_prod_red   <= wcr_pkg::PROD_W'(r_lin_red) * wcr_pkg::PROD_W'(wcr_pkg::WT_RED);
            r_prod_green <= wcr_pkg::PROD_W'(r_lin_green)
                            * wcr_pkg::PROD_W'(wcr_pkg::WT_GREEN);
            r_prod_blue  <= wcr_pkg::PROD_W'(r_lin_blue) * wcr_pkg::PROD_W'(wcr_pkg::WT_BLUE);
        end
    end

    // Sum and round to luminance units
    always_comb begin
        n_sum = wcr_pkg::SUM_W'(r_prod_red) + wcr_pkg::SUM_W'(r_prod_green)
              + wcr_pkg::SUM_W'(r_prod_blue) + wcr_pkg::SUM_W'(wcr_pkg::ROUND_HALF);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[2]) begin
            r_lum <= n_sum[wcr_pkg::WT_FRAC +: wcr_pkg::LUM_W];
        end
    end

    assign o_lum = r_lum;

endmodule

### src/wcr_merge.sv
// ----------------------------------------------------------------------------
// wcr_merge
// Merge the two lanes: order the luminances and form dividend and divisor.
// ----------------------------------------------------------------------------
module wcr_merge (
    input  logic                       i_clk,
    input  logic                       i_adv,
    input  logic [wcr_pkg::LUM_W-1:0]  i_lum_a,
    input  logic [wcr_pkg::LUM_W-1:0]  i_lum_b,
    output wcr_pkg::t_div_in           o_div
);

    logic [wcr_pkg::LUM_W-1:0] n_hi;
    logic [wcr_pkg::LUM_W-1:0] n_lo;
    wcr_pkg::t_div_in          n_div;
    wcr_pkg::t_div_in          r_div;

    always_comb begin
        if (i_lum_a > i_lum_b) begin
            n_hi = i_lum_a;
            n_lo = i_lum_b;
        end else begin
            n_hi = i_lum_b;
            n_lo = i_lum_a;
        end
        n_div.dvd   = wcr_pkg::DVD_W'(n_hi + wcr_pkg::LUM_W'(wcr_pkg::LUM_OFF))
                      << wcr_pkg::RATIO_FRAC_BITS;
        n_div.dvs   = wcr_pkg::DVS_W'(n_lo + wcr_pkg::LUM_W'(wcr_pkg::LUM_OFF));
        n_div.lum_a = i_lum_a;
        n_div.lum_b = i_lum_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

### src/wcr_div_pipe.sv
// ----------------------------------------------------------------------------
// wcr_div_pipe
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module wcr_div_pipe (
    input  logic                          i_clk,
    input  logic [wcr_pkg::RATIO_W-1:0]   i_adv,
    input  wcr_pkg::t_div_in              i_div,
    output logic [wcr_pkg::RATIO_W-1:0]   o_quo,
    output logic [wcr_pkg::LUM_W-1:0]     o_lum_a,
    output logic [wcr_pkg::LUM_W-1:0]     o_lum_b
);

    logic [wcr_pkg::DVD_W-1:0]   r_rem [wcr_pkg::RATIO_W];
    logic [wcr_pkg::DVS_W-1:0]   r_dvs [wcr_pkg::RATIO_W];
    logic [wcr_pkg::RATIO_W-1:0] r_quo [wcr_pkg::RATIO_W];
    logic [wcr_pkg::LUM_W-1:0]   r_la  [wcr_pkg::RATIO_W];
    logic [wcr_pkg::LUM_W-1:0]   r_lb  [wcr_pkg::RATIO_W];

    for (genvar j = 0; j < wcr_pkg::RATIO_W; j++) begin : g_stage
        localparam int QBIT = wcr_pkg::RATIO_W - 1 - j;

        logic [wcr_pkg::DVD_W-1:0]   w_rem;
        logic [wcr_pkg::DVS_W-1:0]   w_dvs;
        logic [wcr_pkg::RATIO_W-1:0] w_quo;
        logic [wcr_pkg::LUM_W-1:0]   w_la;
        logic [wcr_pkg::LUM_W-1:0]   w_lb;
        logic [wcr_pkg::CMP_W-1:0]   n_trial;
        logic [wcr_pkg::DVD_W-1:0]   n_rem;
        logic [wcr_pkg::RATIO_W-1:0] n_quo;

        if (j == 0) begin : g_first
            assign w_rem = i_div.dvd;
            assign w_dvs = i_div.dvs;
            assign w_quo = '0;
            assign w_la  = i_div.lum_a;
            assign w_lb  = i_div.lum_b;
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_dvs = r_dvs[j-1];
            assign w_quo = r_quo[j-1];
            assign w_la  = r_la[j-1];
            assign w_lb  = r_lb[j-1];
        end

        // Try subtracting the divisor aligned to this quotient bit
        always_comb begin
            n_trial = wcr_pkg::CMP_W'(w_dvs) << QBIT;
            if (wcr_pkg::CMP_W'(w_rem) >= n_trial) begin
                n_rem = wcr_pkg::DVD_W'(wcr_pkg::CMP_W'(w_rem) - n_trial);
                n_quo = w_quo | (wcr_pkg::RATIO_W'(1) << QBIT);
            end else begin
                n_rem = w_rem;
                n_quo = w_quo;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[j]) begin
                r_rem[j] <= n_rem;
                r_dvs[j] <= w_dvs;
                r_quo[j] <= n_quo;
                r_la[j]  <= w_la;
                r_lb[j]  <= w_lb;
            end
        end
    end

    assign o_quo   = r_quo[wcr_pkg::RATIO_W-1];
    assign o_lum_a = r_la[wcr_pkg::RATIO_W-1];
    assign o_lum_b = r_lb[wcr_pkg::RATIO_W-1];

endmodule
